>>> rtl/double_ended_queue_with_search_defines.svh
// Assertion macros shared by the deque checker.
`ifndef DOUBLE_ENDED_QUEUE_WITH_SEARCH_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_WITH_SEARCH_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define DEQS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("deque check failed: same-cycle implication");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define DEQS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("deque check failed: next-cycle implication");

`endif

>>> rtl/deqs_pkg.sv
// Shared types and constants of the double-ended queue with search.
`timescale 1ns / 1ps

package deqs_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int VAL_W     = 32;
	localparam int OP_W      = 3;
	localparam int STAT_W    = 2;
	localparam int POS_W     = 13;

	// operation codes on the input port
	localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
	localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
	localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
	localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
	localparam logic [OP_W-1:0] OP_SEARCH     = 3'd4;

	typedef enum logic [STAT_W-1:0] {
		STAT_DONE     = 2'd0,
		STAT_EMPTY    = 2'd1,
		STAT_FULL     = 2'd2,
		STAT_NOTFOUND = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		K_PUSH_FRONT,
		K_PUSH_BACK,
		K_POP_FRONT,
		K_POP_BACK,
		K_SEARCH,
		K_NOP
	} kind_t;

	typedef struct packed {
		kind_t              kind;
		logic signed [VAL_W-1:0] value;
	} cmd_t;

endpackage

>>> rtl/deqs_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module deqs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

>>> rtl/deqs_front.sv
// Front end: accept input transfers, classify the operation, queue commands.
`timescale 1ns / 1ps

module deqs_front import deqs_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [OP_W-1:0]         operation,
	input  logic signed [VAL_W-1:0] value,
	output logic                    cmd_valid,
	output cmd_t                    cmd,
	input  logic                    cmd_pop
);

	cmd_t       fifo_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	kind_t      kind;
	logic       push;

	always_comb begin
		case (operation)
			OP_PUSH_FRONT: kind = K_PUSH_FRONT;
			OP_PUSH_BACK:  kind = K_PUSH_BACK;
			OP_POP_FRONT:  kind = K_POP_FRONT;
			OP_POP_BACK:   kind = K_POP_BACK;
			OP_SEARCH:     kind = K_SEARCH;
			default:       kind = K_NOP;
		endcase
	end

	assign in_ready  = (cnt_q != 2'd2);
	assign push      = in_valid && in_ready;
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= '{kind: kind, value: value};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (cmd_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, cmd_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

>>> rtl/deqs_back.sv
// Back end: execute queued commands on the ring, run searches, hold the result.
`timescale 1ns / 1ps

module deqs_back import deqs_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	input  cmd_t              cmd,
	output logic              cmd_pop,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [STAT_W-1:0] status,
	output logic [POS_W-1:0]  position
);

	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int SW = IW + 1;

	typedef enum logic [1:0] {S_IDLE, S_SEARCH, S_REPORT} state_t;

	state_t                  state_q;
	logic [IW-1:0]           front_q;
	logic [CW-1:0]           occ_q;
	logic                    out_valid_q;
	status_t                 status_q;
	logic [POS_W-1:0]        position_q;
	logic signed [VAL_W-1:0] key_q;
	logic [IW-1:0]           rd_addr_q;
	logic [CW-1:0]           rd_cnt_q;
	logic                    cmp_vld_q;
	logic [CW-1:0]           cmp_off_q;
	status_t                 sr_status_q;
	logic [POS_W-1:0]        sr_pos_q;

	logic                    res_free;
	logic                    full;
	logic                    empty;
	logic [IW-1:0]           front_dec;
	logic [IW-1:0]           front_inc;
	logic [IW-1:0]           rd_addr_inc;
	logic [SW-1:0]           back_sum;
	logic [IW-1:0]           back_addr;
	logic                    wr_en;
	logic [IW-1:0]           wr_addr;
	logic                    rd_en;
	logic [VAL_W-1:0]        rd_data;
	logic                    hit;
	logic                    last;

	assign res_free  = !out_valid_q || out_ready;
	assign full      = (occ_q == CW'(DEPTH));
	assign empty     = (occ_q == '0);
	assign front_dec = (front_q == '0) ? IW'(DEPTH - 1) : front_q - IW'(1);
	assign front_inc = (front_q == IW'(DEPTH - 1)) ? '0 : front_q + IW'(1);
	assign rd_addr_inc = (rd_addr_q == IW'(DEPTH - 1)) ? '0 : rd_addr_q + IW'(1);

	always_comb begin
		back_sum = SW'(front_q) + SW'(occ_q);
		if (back_sum >= SW'(DEPTH)) begin
			back_sum = back_sum - SW'(DEPTH);
		end
		back_addr = back_sum[IW-1:0];
	end

	assign cmd_pop = (state_q == S_IDLE) && cmd_valid && ((cmd.kind == K_SEARCH) || res_free);
	assign wr_en   = cmd_pop && !full &&
		((cmd.kind == K_PUSH_FRONT) || (cmd.kind == K_PUSH_BACK));
	assign wr_addr = (cmd.kind == K_PUSH_FRONT) ? front_dec : back_addr;
	assign rd_en   = (state_q == S_SEARCH) && (rd_cnt_q < occ_q);
	assign hit     = cmp_vld_q && (rd_data == key_q);
	assign last    = cmp_vld_q && (cmp_off_q == occ_q - CW'(1));

	deqs_ram #(
		.WIDTH (VAL_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (cmd.value),
		.rd_en   (rd_en),
		.rd_addr (rd_addr_q),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			front_q     <= '0;
			occ_q       <= '0;
			out_valid_q <= 1'b0;
			status_q    <= STAT_DONE;
			position_q  <= '0;
			key_q       <= '0;
			rd_addr_q   <= '0;
			rd_cnt_q    <= '0;
			cmp_vld_q   <= 1'b0;
			cmp_off_q   <= '0;
			sr_status_q <= STAT_DONE;
			sr_pos_q    <= '0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (cmd_pop && (cmd.kind != K_SEARCH)) begin
						out_valid_q <= 1'b1;
						position_q  <= '0;
						status_q    <= STAT_DONE;
					end
					if (cmd_pop) begin
						case (cmd.kind)
							K_PUSH_FRONT: begin
								if (full) begin
									status_q <= STAT_FULL;
								end else begin
									front_q <= front_dec;
									occ_q   <= occ_q + CW'(1);
								end
							end
							K_PUSH_BACK: begin
								if (full) begin
									status_q <= STAT_FULL;
								end else begin
									occ_q <= occ_q + CW'(1);
								end
							end
							K_POP_FRONT: begin
								if (empty) begin
									status_q <= STAT_EMPTY;
								end else begin
									occ_q   <= occ_q - CW'(1);
									front_q <= (occ_q == CW'(1)) ? '0 : front_inc;
								end
							end
							K_POP_BACK: begin
								if (empty) begin
									status_q <= STAT_EMPTY;
								end else begin
									occ_q <= occ_q - CW'(1);
									if (occ_q == CW'(1)) begin
										front_q <= '0;
									end
								end
							end
							K_SEARCH: begin
								key_q     <= cmd.value;
								rd_addr_q <= front_q;
								rd_cnt_q  <= '0;
								cmp_vld_q <= 1'b0;
								if (empty) begin
									sr_status_q <= STAT_NOTFOUND;
									sr_pos_q    <= '0;
									state_q     <= S_REPORT;
								end else begin
									state_q <= S_SEARCH;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_SEARCH: begin
					if (rd_en) begin
						rd_addr_q <= rd_addr_inc;
						rd_cnt_q  <= rd_cnt_q + CW'(1);
					end
					cmp_vld_q <= rd_en;
					cmp_off_q <= rd_cnt_q;
					if (hit) begin
						sr_status_q <= STAT_DONE;
						sr_pos_q    <= POS_W'(cmp_off_q) + POS_W'(1);
						state_q     <= S_REPORT;
					end else if (last) begin
						sr_status_q <= STAT_NOTFOUND;
						sr_pos_q    <= '0;
						state_q     <= S_REPORT;
					end
				end
				S_REPORT: begin
					if (res_free) begin
						out_valid_q <= 1'b1;
						status_q    <= sr_status_q;
						position_q  <= sr_pos_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign position  = position_q;

endmodule

>>> rtl/double_ended_queue_with_search.sv
// Top level of the double-ended queue with linear search.
`timescale 1ns / 1ps

// Bounded deque of DEPTH signed 32-bit values held in a ring in one RAM, with a
// front index and an occupancy count. Each input transfer carries an operation
// (push front, push back, pop front, pop back, search; other codes do nothing)
// and a value, and yields exactly one result transfer with status and position.
// A two-entry command queue in the front end keeps accepting transfers while
// the back end works or a result waits to be taken. In the back end, pushes,
// pops and unused codes complete as the command is taken; a search reads one
// entry per cycle through the single RAM read port, compares the registered
// read data with the key, and posts its result once the result register is
// free. A search stops at the first match.
// No clearing pass follows reset; only slots that hold entries are ever read.
// Popped values are not returned; position is nonzero only for a found search.
module double_ended_queue_with_search import deqs_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [OP_W-1:0]         operation,
	input  logic signed [VAL_W-1:0] value,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [STAT_W-1:0]       status,
	output logic [POS_W-1:0]        position
);

	// command transfer between front and back end
	logic cmd_valid;
	logic cmd_pop;
	cmd_t cmd;

	// accept and classify, queue up to two commands
	deqs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.operation (operation),
		.value     (value),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	// execute on the ring, search, hold the result until transferred
	deqs_back #(
		.DEPTH (DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.position  (position)
	);

endmodule

>>> rtl/deqs_checker.sv
// Port-level checker for the deque, bound to the top level.
`timescale 1ns / 1ps
`include "double_ended_queue_with_search_defines.svh"

module deqs_checker import deqs_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input logic [STAT_W-1:0] status,
	input logic [POS_W-1:0]  position
);

	// transfers accepted whose result has not yet been taken
	logic [3:0] pending_q;
	logic       in_xfer;
	logic       out_xfer;

	assign in_xfer  = in_valid && in_ready;
	assign out_xfer = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			pending_q <= pending_q + 4'(in_xfer) - 4'(out_xfer);
		end
	end

	`DEQS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status) && $stable(position))
	`DEQS_ASSERT_NOW(a_pos_only_found, out_valid && (position != '0), (status == STAT_DONE) && (position <= POS_W'(DEPTH)))
	`DEQS_ASSERT_NOW(a_no_invented, out_valid, pending_q != '0)
	`DEQS_ASSERT_NOW(a_pending_bound, 1'b1, pending_q <= 4'd4)

endmodule

bind double_ended_queue_with_search deqs_checker #(
	.DEPTH (DEPTH)
) u_deqs_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.status    (status),
	.position  (position)
);

>>> tb/double_ended_queue_with_search_tb.sv
// Self-checking testbench for the double-ended queue with linear search.
`timescale 1ns / 1ps

module double_ended_queue_with_search_tb import deqs_pkg::*;;

	localparam int DEPTH           = DEPTH_DEF;
	localparam int RANDOM_ITEMS    = 480;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int WATCHDOG_LIMIT  = 5000;
	// leave a margin after the last result before the final check
	localparam int TAIL_CYCLES     = DEPTH + 8;
	localparam int REPORT_LIMIT    = 10;

	// codes the block treats as no operation
	localparam logic [OP_W-1:0] OP_UNUSED_LO  = 3'd5;
	localparam logic [OP_W-1:0] OP_UNUSED_MID = 3'd6;
	localparam logic [OP_W-1:0] OP_UNUSED_HI  = 3'd7;

	// Mirror of the ring contents plus the list of results still owed by the block.
	class deque_scoreboard;
		logic [VAL_W-1:0]  slot [DEPTH];
		int                head;
		int                fill;
		logic [STAT_W-1:0] due_status [$];
		logic [POS_W-1:0]  due_position [$];
		int                failures;

		function new();
			head     = 0;
			fill     = 0;
			failures = 0;
		endfunction

		function int ring(int k);
			return (head + k) % DEPTH;
		endfunction

		function logic [VAL_W-1:0] held_entry(int k);
			return slot[ring(k)];
		endfunction

		function int pending();
			return due_status.size();
		endfunction

		// Advance the mirror by one accepted request and queue the result it owes.
		function void apply_request(logic [OP_W-1:0] op, logic [VAL_W-1:0] val);
			status_t          st;
			logic [POS_W-1:0] pos;
			st  = STAT_DONE;
			pos = '0;
			case (op)
			OP_PUSH_FRONT: begin
				if (fill == DEPTH) begin
					st = STAT_FULL;
				end else begin
					head       = (head + DEPTH - 1) % DEPTH;
					slot[head] = val;
					fill++;
				end
			end
			OP_PUSH_BACK: begin
				if (fill == DEPTH) begin
					st = STAT_FULL;
				end else begin
					slot[ring(fill)] = val;
					fill++;
				end
			end
			OP_POP_FRONT: begin
				if (fill == 0) begin
					st = STAT_EMPTY;
				end else begin
					head = ring(1);
					fill--;
					if (fill == 0) head = 0;
				end
			end
			OP_POP_BACK: begin
				if (fill == 0) begin
					st = STAT_EMPTY;
				end else begin
					fill--;
					if (fill == 0) head = 0;
				end
			end
			OP_SEARCH: begin
				// first match from the front wins
				st = STAT_NOTFOUND;
				for (int k = 0; k < fill; k++) begin
					if (st == STAT_NOTFOUND && slot[ring(k)] == val) begin
						st  = STAT_DONE;
						pos = POS_W'(k + 1);
					end
				end
			end
			default: begin
			end
			endcase
			due_status.push_back(st);
			due_position.push_back(pos);
		endfunction

		// Compare one accepted result with the oldest one owed.
		function void compare_reply(logic [STAT_W-1:0] st, logic [POS_W-1:0] pos);
			logic [STAT_W-1:0] want_st;
			logic [POS_W-1:0]  want_pos;
			if (due_status.size() == 0) begin
				failures++;
				if (failures <= REPORT_LIMIT)
					$display("unexpected result: status %0d position %0d", st, pos);
				return;
			end
			want_st  = due_status.pop_front();
			want_pos = due_position.pop_front();
			if (st !== want_st || pos !== want_pos) begin
				failures++;
				if (failures <= REPORT_LIMIT)
					$display("mismatch: expected status %0d position %0d, got status %0d position %0d",
						want_st, want_pos, st, pos);
			end
		endfunction
	endclass

	logic                    clk       = 1'b0;
	logic                    arst_n    = 1'b0;
	logic                    in_valid  = 1'b0;
	logic                    in_ready;
	logic [OP_W-1:0]         operation = OP_PUSH_FRONT;
	logic signed [VAL_W-1:0] value     = '0;
	logic                    out_valid;
	logic                    out_ready = 1'b0;
	logic [STAT_W-1:0]       status;
	logic [POS_W-1:0]        position;

	deque_scoreboard deque_sb;
	int              send_idle_pct = 0;
	int              recv_idle_pct = 0;
	bit              hold_off_req  = 1'b0;
	int              quiet_cycles  = 0;

	double_ended_queue_with_search #(
		.DEPTH(DEPTH)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.operation(operation),
		.value    (value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status   (status),
		.position (position)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Sample both channels at the edge; values read here are the ones before the edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) deque_sb.apply_request(operation, value);
			if (out_valid && out_ready) deque_sb.compare_reply(status, position);
		end
	end

	// End the run if neither channel moves a transfer for too long.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no transfer for %0d cycles", quiet_cycles);
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	// Receiver: stall at random, or hold off for a long stretch when asked.
	initial begin : receiver
		int left;
		left = 0;
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				left         = HOLD_OFF_CYCLES;
			end
			if (left > 0) begin
				left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end
	end

	// Offer one request, with random idle cycles first; return at the edge of its transfer.
	task automatic send_item(input logic [OP_W-1:0] op, input logic [VAL_W-1:0] val);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		operation <= op;
		value     <= val;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	// Drop valid and hold until every owed result has been taken.
	task automatic wait_drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (deque_sb.pending() != 0);
	endtask

	initial begin : stimulus
		int              sent;
		int              r;
		bit              filling;
		logic [OP_W-1:0] op;
		logic [VAL_W-1:0] val;

		deque_sb = new();
		filling  = 1'b1;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty cases, unused codes, wrap of the front index, full, first match.
		send_item(OP_POP_FRONT, 32'h0000_0000);
		send_item(OP_POP_BACK, 32'hFFFF_FFFF);
		send_item(OP_SEARCH, 32'h0000_0000);
		send_item(OP_UNUSED_LO, 32'h1234_5678);
		send_item(OP_UNUSED_MID, 32'h8765_4321);
		send_item(OP_UNUSED_HI, 32'hFFFF_FFFF);
		send_item(OP_PUSH_FRONT, 32'h8000_0000);
		send_item(OP_PUSH_FRONT, 32'hFFFF_FFFF);
		for (int i = 0; i < DEPTH - 2; i++)
			send_item(OP_PUSH_BACK, VAL_W'(i - 7));
		send_item(OP_PUSH_BACK, 32'h7FFF_FFFF);
		send_item(OP_PUSH_FRONT, 32'h7FFF_FFFF);
		send_item(OP_SEARCH, 32'hFFFF_FFFF);
		send_item(OP_SEARCH, VAL_W'(DEPTH - 9));
		send_item(OP_SEARCH, 32'h7FFF_FFFF);
		send_item(OP_SEARCH, 32'h8000_0000);
		send_item(OP_POP_FRONT, 32'h0000_0000);
		send_item(OP_POP_BACK, 32'h0000_0000);
		send_item(OP_SEARCH, VAL_W'(DEPTH - 9));
		wait_drain();

		// Random: three idling phases; the last one starts with a long receiver hold-off.
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
			0: begin
				send_idle_pct = 10;
				recv_idle_pct = 85;
			end
			1: begin
				send_idle_pct = 85;
				recv_idle_pct = 10;
			end
			default: begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
				hold_off_req  = 1'b1;
			end
			endcase
			sent = 0;
			while (sent < RANDOM_ITEMS / 3) begin
				// swing between filling and draining so both full and empty come up often
				if (deque_sb.fill >= DEPTH && $urandom_range(0, 2) == 0) filling = 1'b0;
				if (deque_sb.fill == 0 && $urandom_range(0, 2) == 0) filling = 1'b1;

				r = $urandom_range(0, 99);
				if (r < 3)
					op = OP_UNUSED_LO + OP_W'($urandom_range(0, 2));
				else if (r < 28)
					op = OP_SEARCH;
				else if ((filling && r < 78) || (!filling && r < 48))
					op = $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
				else
					op = $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;

				// small values give duplicates, so the first match matters
				case ($urandom_range(0, 3))
				0: val = $urandom;
				1: begin
					val = $urandom_range(0, 6);
					val = val - 32'd3;
				end
				2: begin
					case ($urandom_range(0, 3))
					0: val = 32'h8000_0000;
					1: val = 32'h7FFF_FFFF;
					2: val = 32'hFFFF_FFFF;
					default: val = 32'h0000_0000;
					endcase
				end
				default: begin
					if (deque_sb.fill > 0)
						val = deque_sb.held_entry($urandom_range(0, deque_sb.fill - 1));
					else
						val = $urandom;
				end
				endcase

				send_item(op, val);
				if (op <= OP_SEARCH) sent++;
			end
			wait_drain();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (deque_sb.pending() != 0)
			$display("%0d expected results never arrived", deque_sb.pending());
		if (deque_sb.failures == 0 && deque_sb.pending() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

>>> filelist.f
+incdir+rtl
rtl/deqs_pkg.sv
rtl/deqs_ram.sv
rtl/deqs_front.sv
rtl/deqs_back.sv
rtl/double_ended_queue_with_search.sv
rtl/deqs_checker.sv
tb/double_ended_queue_with_search_tb.sv
